>>> design/mvna_pkg.sv
// Shared types, widths and helpers for the mesh vertex normal accumulator.
// No dependencies; every design file but mvna_ram imports this package.
package mvna_pkg;

    localparam int VERTEX_COUNT = 1024;
    localparam int IDX_W        = $clog2(VERTEX_COUNT);
    localparam int POS_W        = 16;
    localparam int NRM_W        = 16;
    localparam int ENTRY_W      = 3 * POS_W;
    localparam int DIFF_W       = POS_W + 1;
    localparam int ACC_W        = 40;
    localparam int MAG_W        = 24;
    localparam int MUL_W        = MAG_W + 1;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int LEN_W        = 50;
    localparam int RAD_W        = 62;
    localparam int ROOT_W       = RAD_W / 2;
    localparam int NUM_W        = 46;
    localparam int QUO_W        = 17;
    localparam int STEP_W       = 3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RPOS,
        S_DIFF,
        S_CROSS,
        S_RNRM,
        S_ACC,
        S_NORM,
        S_SQ,
        S_SQST,
        S_SQRT,
        S_DVST,
        S_DIV,
        S_WB
    } t_state;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_TRI  = 1'b1
    } t_action;

    // Applies the sign to a quotient magnitude and saturates to Q1.15.
    function automatic logic signed [NRM_W-1:0] sat_q15(input logic [QUO_W-1:0] q,
                                                       input logic neg);
        logic signed [NRM_W-1:0] res;
        if (neg) begin
            if (q >= QUO_W'(32768)) begin
                res = 16'sh8000;
            end else begin
                res = 16'sd0 - $signed(q[NRM_W-1:0]);
            end
        end else begin
            if (q > QUO_W'(32767)) begin
                res = 16'sh7fff;
            end else begin
                res = $signed(q[NRM_W-1:0]);
            end
        end
        return res;
    endfunction

endpackage

>>> design/mvna_ram.sv
// Generic simple dual-port RAM: one write port and one read port with registered data.
// No package dependencies.
module mvna_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

>>> design/mvna_isqrt.sv
// Iterative integer square root, one result bit per cycle.
// Depends on mvna_pkg for the radicand and root widths.
module mvna_isqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [mvna_pkg::RAD_W-1:0]  i_rad,
    output logic                        o_done,
    output logic [mvna_pkg::ROOT_W-1:0] o_root
);
    import mvna_pkg::*;

    logic [RAD_W-1:0]  r_n;
    logic [31:0]       r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [4:0]        r_cnt;
    logic              r_run;
    logic              r_done;
    logic [33:0]       rem_sh;
    logic [33:0]       trial;
    logic              ge;
    logic [33:0]       rem_nx;

    always_comb begin
        rem_sh = {r_rem, r_n[RAD_W-1 -: 2]};
        trial  = {1'b0, r_root, 2'b01};
        ge     = rem_sh >= trial;
        rem_nx = ge ? (rem_sh - trial) : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && r_cnt == 5'd0) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n    <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= 5'(ROOT_W - 1);
        end else if (r_run) begin
            r_n    <= {r_n[RAD_W-3:0], 2'b00};
            r_rem  <= rem_nx[31:0];
            r_root <= {r_root[ROOT_W-2:0], ge};
            r_cnt  <= r_cnt - 5'd1;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

>>> design/mvna_divlane.sv
// Restoring divider lane, one quotient bit per cycle.
// Depends on mvna_pkg for the numerator, divisor and quotient widths.
module mvna_divlane (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [mvna_pkg::NUM_W-1:0]  i_num,
    input  logic [mvna_pkg::ROOT_W-1:0] i_den,
    output logic                        o_done,
    output logic [mvna_pkg::QUO_W-1:0]  o_quo
);
    import mvna_pkg::*;

    logic [31:0]       r_rem;
    logic [QUO_W-1:0]  r_low;
    logic [QUO_W-1:0]  r_quo;
    logic [ROOT_W-1:0] r_den;
    logic [4:0]        r_cnt;
    logic              r_run;
    logic              r_done;
    logic [32:0]       t;
    logic              ge;
    logic [32:0]       t_nx;

    always_comb begin
        t    = {r_rem, r_low[QUO_W-1]};
        ge   = t >= {2'b00, r_den};
        t_nx = ge ? (t - {2'b00, r_den}) : t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && r_cnt == 5'd0) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // The numerator is below the divisor times 2^QUO_W, so the upper part starts as a
    // valid partial remainder.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= 32'(i_num[NUM_W-1:QUO_W]);
            r_low <= i_num[QUO_W-1:0];
            r_den <= i_den;
            r_quo <= '0;
            r_cnt <= 5'(QUO_W - 1);
        end else if (r_run) begin
            r_rem <= t_nx[31:0];
            r_low <= {r_low[QUO_W-2:0], 1'b0};
            r_quo <= {r_quo[QUO_W-2:0], ge};
            r_cnt <= r_cnt - 5'd1;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

>>> design/mesh_vertex_normal_accumulator.sv
// Mesh vertex normal accumulator top; depends on mvna_pkg, mvna_ram, mvna_isqrt, mvna_divlane.
// A load is written when accepted and leaves busy low. A triangle holds busy through the
// position reads and the cross product, then per corner through the normal read, accumulation,
// shift steps, sum of squares, square root and divider lanes; a zero-length corner skips the
// last three. One result beat per corner, a single-cycle strobe; the receiver cannot stall.
// Reset is synchronous and clears the control state only; RAM contents are undefined.
module mesh_vertex_normal_accumulator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_action,
    input  logic [mvna_pkg::IDX_W-1:0]        i_vertex_index,
    input  logic signed [mvna_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [mvna_pkg::POS_W-1:0] i_pos_y,
    input  logic signed [mvna_pkg::POS_W-1:0] i_pos_z,
    input  logic [mvna_pkg::IDX_W-1:0]        i_corner_a,
    input  logic [mvna_pkg::IDX_W-1:0]        i_corner_b,
    input  logic [mvna_pkg::IDX_W-1:0]        i_corner_c,
    input  logic                              i_end_of_mesh,
    output logic                              o_valid,
    output logic [mvna_pkg::IDX_W-1:0]        o_vertex_id,
    output logic signed [mvna_pkg::NRM_W-1:0] o_normal_x,
    output logic signed [mvna_pkg::NRM_W-1:0] o_normal_y,
    output logic signed [mvna_pkg::NRM_W-1:0] o_normal_z,
    output logic                              o_degenerate,
    output logic                              o_last_corner,
    output logic                              o_mesh_done
);
    import mvna_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [IDX_W-1:0]         r_idx [3];
    logic                     r_eom;
    logic [ENTRY_W-1:0]       r_pos [3];
    logic signed [DIFF_W-1:0] r_d1 [3];
    logic signed [DIFF_W-1:0] r_d2 [3];
    logic signed [ACC_W-1:0]  r_cr [3];
    logic [STEP_W-1:0]        r_step;
    logic [1:0]               r_ci;
    logic [ACC_W-1:0]         r_mag [3];
    logic                     r_neg [3];
    logic [ACC_W-1:0]         r_m;
    logic signed [PROD_W-1:0] r_prod;
    logic [LEN_W-1:0]         r_len2;
    logic signed [NRM_W-1:0]  r_res [3];
    logic                     r_deg;

    logic                     accept;
    logic                     load_acc;
    logic                     tri_acc;
    logic                     pos_we;
    logic [IDX_W-1:0]         pos_raddr;
    logic [ENTRY_W-1:0]       pos_rdata;
    logic                     nrm_we;
    logic [IDX_W-1:0]         nrm_waddr;
    logic [ENTRY_W-1:0]       nrm_wdata;
    logic [IDX_W-1:0]         nrm_raddr;
    logic [ENTRY_W-1:0]       nrm_rdata;
    logic                     sq_start;
    logic                     sq_done;
    logic [ROOT_W-1:0]        sq_root;
    logic                     dv_start;
    logic [2:0]               dv_done;
    logic [QUO_W-1:0]         dv_quo [3];
    logic [NUM_W-1:0]         dv_num [3];
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic                     dup;
    logic [1:0]               cnt;
    logic signed [ACC_W-1:0]  acc [3];
    logic [ACC_W-1:0]         acc_mag [3];
    logic [ACC_W-1:0]         acc_max;
    logic [1:0]               cr_sel;

    assign accept   = start && !busy;
    assign load_acc = accept && (i_action == ACT_LOAD);
    assign tri_acc  = accept && (i_action == ACT_TRI);

    mvna_ram #(.DEPTH(VERTEX_COUNT), .WIDTH(ENTRY_W)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (i_vertex_index),
        .i_wdata ({i_pos_z, i_pos_y, i_pos_x}),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rdata)
    );

    mvna_ram #(.DEPTH(VERTEX_COUNT), .WIDTH(ENTRY_W)) u_nrm_ram (
        .i_clk   (i_clk),
        .i_we    (nrm_we),
        .i_waddr (nrm_waddr),
        .i_wdata (nrm_wdata),
        .i_raddr (nrm_raddr),
        .o_rdata (nrm_rdata)
    );

    mvna_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   ({r_len2, 12'b0}),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    for (genvar g = 0; g < 3; g++) begin : g_div
        assign dv_num[g] = NUM_W'({r_mag[g][MAG_W-1:0], 21'b0})
                         + NUM_W'(sq_root[ROOT_W-1:1]);
        mvna_divlane u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (dv_start),
            .i_num   (dv_num[g]),
            .i_den   (sq_root),
            .o_done  (dv_done[g]),
            .o_quo   (dv_quo[g])
        );
    end

    // Corner bookkeeping: a repeated corner only renormalizes what the earlier one wrote,
    // while the first occurrence takes the face normal once per appearance.
    always_comb begin
        dup = (r_ci == 2'd1 && r_idx[1] == r_idx[0])
           || (r_ci == 2'd2 && (r_idx[2] == r_idx[0] || r_idx[2] == r_idx[1]));
        cnt = 2'd0;
        for (int j = 0; j < 3; j++) begin
            if (r_idx[j] == r_idx[r_ci]) begin
                cnt = cnt + 2'd1;
            end
        end
        for (int k = 0; k < 3; k++) begin
            acc[k] = ACC_W'($signed(nrm_rdata[NRM_W*k +: NRM_W])) <<< 1;
            if (!dup) begin
                case (cnt)
                    2'd2:    acc[k] = acc[k] + (r_cr[k] <<< 1);
                    2'd3:    acc[k] = acc[k] + (r_cr[k] <<< 1) + r_cr[k];
                    default: acc[k] = acc[k] + r_cr[k];
                endcase
            end
            acc_mag[k] = acc[k][ACC_W-1] ? ACC_W'(-acc[k]) : ACC_W'(acc[k]);
        end
        acc_max = acc_mag[0];
        if (acc_mag[1] > acc_max) begin
            acc_max = acc_mag[1];
        end
        if (acc_mag[2] > acc_max) begin
            acc_max = acc_mag[2];
        end
    end

    // One shared multiplier serves the cross product and the sum of squares.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_SQ) begin
            case (r_step)
                3'd0:    mul_a = $signed({1'b0, r_mag[0][MAG_W-1:0]});
                3'd1:    mul_a = $signed({1'b0, r_mag[1][MAG_W-1:0]});
                default: mul_a = $signed({1'b0, r_mag[2][MAG_W-1:0]});
            endcase
            mul_b = mul_a;
        end else begin
            case (r_step)
                3'd0:    begin mul_a = MUL_W'(r_d1[1]); mul_b = MUL_W'(r_d2[2]); end
                3'd1:    begin mul_a = MUL_W'(r_d1[2]); mul_b = MUL_W'(r_d2[1]); end
                3'd2:    begin mul_a = MUL_W'(r_d1[2]); mul_b = MUL_W'(r_d2[0]); end
                3'd3:    begin mul_a = MUL_W'(r_d1[0]); mul_b = MUL_W'(r_d2[2]); end
                3'd4:    begin mul_a = MUL_W'(r_d1[0]); mul_b = MUL_W'(r_d2[1]); end
                default: begin mul_a = MUL_W'(r_d1[1]); mul_b = MUL_W'(r_d2[0]); end
            endcase
        end
    end

    assign cr_sel = 2'((r_step - 3'd1) >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (tri_acc) n_state = S_RPOS;
            S_RPOS:  if (r_step == 3'd3) n_state = S_DIFF;
            S_DIFF:  n_state = S_CROSS;
            S_CROSS: if (r_step == 3'd6) n_state = S_RNRM;
            S_RNRM:  n_state = S_ACC;
            S_ACC:   n_state = S_NORM;
            S_NORM: begin
                if (r_m == '0) begin
                    n_state = S_WB;
                end else if (r_m < ACC_W'(1 << 24) && r_m >= ACC_W'(1 << 23)) begin
                    n_state = S_SQ;
                end
            end
            S_SQ:    if (r_step == 3'd3) n_state = S_SQST;
            S_SQST:  n_state = S_SQRT;
            S_SQRT:  if (sq_done) n_state = S_DVST;
            S_DVST:  n_state = S_DIV;
            S_DIV:   if (&dv_done) n_state = S_WB;
            S_WB:    n_state = (r_ci == 2'd2) ? S_IDLE : S_RNRM;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        busy      = 1'b1;
        o_valid   = 1'b0;
        pos_we    = 1'b0;
        pos_raddr = r_idx[0];
        nrm_we    = 1'b0;
        nrm_waddr = r_idx[r_ci];
        nrm_wdata = {r_res[2], r_res[1], r_res[0]};
        nrm_raddr = r_idx[r_ci];
        sq_start  = 1'b0;
        dv_start  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                busy      = 1'b0;
                pos_we    = load_acc;
                nrm_we    = load_acc;
                nrm_waddr = i_vertex_index;
                nrm_wdata = '0;
            end
            S_RPOS: begin
                case (r_step)
                    3'd1:    pos_raddr = r_idx[1];
                    3'd2:    pos_raddr = r_idx[2];
                    default: pos_raddr = r_idx[0];
                endcase
            end
            S_SQST:  sq_start = 1'b1;
            S_DVST:  dv_start = 1'b1;
            S_WB: begin
                o_valid = 1'b1;
                nrm_we  = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        unique case (r_state)
            S_IDLE: begin
                r_idx[0] <= i_corner_a;
                r_idx[1] <= i_corner_b;
                r_idx[2] <= i_corner_c;
                r_eom    <= i_end_of_mesh;
                r_step   <= '0;
            end
            S_RPOS: begin
                if (r_step != 3'd0) begin
                    r_pos[r_step[1:0] - 2'd1] <= pos_rdata;
                end
                r_step <= r_step + 3'd1;
            end
            S_DIFF: begin
                for (int k = 0; k < 3; k++) begin
                    r_d1[k] <= DIFF_W'($signed(r_pos[1][POS_W*k +: POS_W]))
                             - DIFF_W'($signed(r_pos[0][POS_W*k +: POS_W]));
                    r_d2[k] <= DIFF_W'($signed(r_pos[2][POS_W*k +: POS_W]))
                             - DIFF_W'($signed(r_pos[0][POS_W*k +: POS_W]));
                    r_cr[k] <= '0;
                end
                r_step <= '0;
            end
            S_CROSS: begin
                // Products arrive in the cycle after their operands; products of even steps add, of odd subtract.
                if (r_step != 3'd0) begin
                    if (r_step[0]) begin
                        r_cr[cr_sel] <= r_cr[cr_sel] + ACC_W'(r_prod);
                    end else begin
                        r_cr[cr_sel] <= r_cr[cr_sel] - ACC_W'(r_prod);
                    end
                end
                r_step <= r_step + 3'd1;
                r_ci   <= '0;
            end
            S_ACC: begin
                for (int k = 0; k < 3; k++) begin
                    r_mag[k] <= acc_mag[k];
                    r_neg[k] <= acc[k][ACC_W-1];
                end
                r_m <= acc_max;
            end
            S_NORM: begin
                // Coarse and fine shift steps bring the largest magnitude into [2^23, 2^24).
                if (r_m == '0) begin
                    for (int k = 0; k < 3; k++) begin
                        r_res[k] <= '0;
                    end
                    r_deg <= 1'b1;
                end else if (r_m >= (ACC_W'(1) << 31)) begin
                    r_m <= r_m >> 8;
                    for (int k = 0; k < 3; k++) begin
                        r_mag[k] <= r_mag[k] >> 8;
                    end
                end else if (r_m >= ACC_W'(1 << 24)) begin
                    r_m <= r_m >> 1;
                    for (int k = 0; k < 3; k++) begin
                        r_mag[k] <= r_mag[k] >> 1;
                    end
                end else if (r_m < ACC_W'(1 << 16)) begin
                    r_m <= r_m << 8;
                    for (int k = 0; k < 3; k++) begin
                        r_mag[k] <= r_mag[k] << 8;
                    end
                end else if (r_m < ACC_W'(1 << 23)) begin
                    r_m <= r_m << 1;
                    for (int k = 0; k < 3; k++) begin
                        r_mag[k] <= r_mag[k] << 1;
                    end
                end
                r_step <= '0;
                r_len2 <= '0;
            end
            S_SQ: begin
                if (r_step != 3'd0) begin
                    r_len2 <= r_len2 + LEN_W'(unsigned'(r_prod));
                end
                r_step <= r_step + 3'd1;
            end
            S_DIV: begin
                for (int k = 0; k < 3; k++) begin
                    r_res[k] <= sat_q15(dv_quo[k], r_neg[k]);
                end
                r_deg <= 1'b0;
            end
            S_WB: begin
                r_ci <= (r_ci == 2'd2) ? 2'd0 : r_ci + 2'd1;
            end
            default: ;
        endcase
    end

    assign o_vertex_id   = r_idx[r_ci];
    assign o_normal_x    = r_res[0];
    assign o_normal_y    = r_res[1];
    assign o_normal_z    = r_res[2];
    assign o_degenerate  = r_deg;
    assign o_last_corner = (r_ci == 2'd2);
    assign o_mesh_done   = (r_ci == 2'd2) && r_eom;

endmodule

>>> bench/mvna_checker.sv
`timescale 1ns / 100ps
// Checker for the mesh vertex normal accumulator: predicts each corner beat and compares.
// Depends on mvna_pkg for widths and the action codes.
module mvna_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic                              i_action,
    input  logic [mvna_pkg::IDX_W-1:0]        i_vertex_index,
    input  logic signed [mvna_pkg::POS_W-1:0] i_pos_x,
    input  logic signed [mvna_pkg::POS_W-1:0] i_pos_y,
    input  logic signed [mvna_pkg::POS_W-1:0] i_pos_z,
    input  logic [mvna_pkg::IDX_W-1:0]        i_corner_a,
    input  logic [mvna_pkg::IDX_W-1:0]        i_corner_b,
    input  logic [mvna_pkg::IDX_W-1:0]        i_corner_c,
    input  logic                              i_end_of_mesh,
    input  logic                              o_valid,
    input  logic [mvna_pkg::IDX_W-1:0]        o_vertex_id,
    input  logic signed [mvna_pkg::NRM_W-1:0] o_normal_x,
    input  logic signed [mvna_pkg::NRM_W-1:0] o_normal_y,
    input  logic signed [mvna_pkg::NRM_W-1:0] o_normal_z,
    input  logic                              o_degenerate,
    input  logic                              o_last_corner,
    input  logic                              o_mesh_done,
    output int                                o_errors,
    output int                                o_pending
);
    import mvna_pkg::*;

    typedef longint t_wide_vec [3];
    typedef logic signed [NRM_W-1:0] t_nrm_vec [3];

    typedef struct {
        logic [IDX_W-1:0]        vid;
        logic signed [NRM_W-1:0] nx, ny, nz;
        logic                    deg, last, done;
    } t_corner_beat;

    logic signed [POS_W-1:0] pos_mem [VERTEX_COUNT][3];
    logic signed [NRM_W-1:0] nrm_mem [VERTEX_COUNT][3];
    t_corner_beat            normal_q [$];

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // Returns 1 for a zero-length vector, which yields the zero normal.
    function automatic bit unit_normal(input t_wide_vec v, output t_nrm_vec res);
        longint unsigned mag [3];
        longint unsigned m, len2, rt, q;
        m = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) begin
            for (int i = 0; i < 3; i++) res[i] = '0;
            return 1'b1;
        end
        while (m >= (64'd1 << 24)) begin
            m >>= 1;
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
        end
        while (m < (64'd1 << 23)) begin
            m <<= 1;
            for (int i = 0; i < 3; i++) mag[i] <<= 1;
        end
        len2 = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        rt   = int_sqrt(len2 << 12);
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << 21) + (rt >> 1)) / rt;
            if (v[i] < 0) res[i] = (q >= 32768) ? 16'sh8000 : -$signed(q[15:0]);
            else          res[i] = (q > 32767) ? 16'sh7fff : $signed(q[15:0]);
        end
        return 1'b0;
    endfunction

    task automatic predict_triangle();
        int           idx [3];
        longint       d1 [3], d2 [3], cr [3];
        t_wide_vec    acc [3];
        t_nrm_vec     nv;
        bit           deg;
        int           cnt;
        t_corner_beat beat;
        idx[0] = i_corner_a;
        idx[1] = i_corner_b;
        idx[2] = i_corner_c;
        for (int k = 0; k < 3; k++) begin
            d1[k] = longint'(pos_mem[idx[1]][k]) - longint'(pos_mem[idx[0]][k]);
            d2[k] = longint'(pos_mem[idx[2]][k]) - longint'(pos_mem[idx[0]][k]);
        end
        cr[0] = d1[1] * d2[2] - d1[2] * d2[1];
        cr[1] = d1[2] * d2[0] - d1[0] * d2[2];
        cr[2] = d1[0] * d2[1] - d1[1] * d2[0];
        for (int i = 0; i < 3; i++) begin
            cnt = 0;
            for (int j = 0; j < 3; j++) if (idx[j] == idx[i]) cnt++;
            for (int k = 0; k < 3; k++)
                acc[i][k] = 2 * longint'(nrm_mem[idx[i]][k]) + cnt * cr[k];
        end
        for (int i = 0; i < 3; i++) begin
            deg = unit_normal(acc[i], nv);
            for (int k = 0; k < 3; k++) nrm_mem[idx[i]][k] = nv[k];
            // A later repeat of this corner starts from the freshly written unit normal.
            for (int j = i + 1; j < 3; j++)
                if (idx[j] == idx[i])
                    for (int k = 0; k < 3; k++) acc[j][k] = 2 * longint'(nv[k]);
            beat.vid  = idx[i];
            beat.nx   = nv[0];
            beat.ny   = nv[1];
            beat.nz   = nv[2];
            beat.deg  = deg;
            beat.last = (i == 2);
            beat.done = (i == 2) && i_end_of_mesh;
            normal_q.push_back(beat);
        end
    endtask

    task automatic report(input string what, input longint exp_v, input longint act_v);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, act_v);
        o_errors++;
    endtask

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_corner_beat exp_b;
        if (i_rst_n && start && !busy) begin
            if (i_action == ACT_LOAD) begin
                pos_mem[i_vertex_index][0] = i_pos_x;
                pos_mem[i_vertex_index][1] = i_pos_y;
                pos_mem[i_vertex_index][2] = i_pos_z;
                for (int k = 0; k < 3; k++) nrm_mem[i_vertex_index][k] = '0;
            end else begin
                predict_triangle();
            end
        end
        if (i_rst_n && o_valid) begin
            if (normal_q.size() == 0) begin
                $display("%0t: unexpected corner beat for vertex %0d", $time, o_vertex_id);
                o_errors++;
            end else begin
                exp_b = normal_q.pop_front();
                if (o_vertex_id !== exp_b.vid) report("vertex_id", exp_b.vid, o_vertex_id);
                if (o_normal_x !== exp_b.nx) report("normal_x", exp_b.nx, o_normal_x);
                if (o_normal_y !== exp_b.ny) report("normal_y", exp_b.ny, o_normal_y);
                if (o_normal_z !== exp_b.nz) report("normal_z", exp_b.nz, o_normal_z);
                if (o_degenerate !== exp_b.deg)
                    report("degenerate", exp_b.deg, o_degenerate);
                if (o_last_corner !== exp_b.last)
                    report("last_corner", exp_b.last, o_last_corner);
                if (o_mesh_done !== exp_b.done)
                    report("mesh_done", exp_b.done, o_mesh_done);
            end
        end
        o_pending = normal_q.size();
    end

endmodule

>>> bench/tb_mesh_vertex_normal_accumulator.sv
`timescale 1ns / 100ps
// Top of the accumulator testbench: clock, reset, stimulus and the verdict.
// Depends on mvna_pkg, mesh_vertex_normal_accumulator and mvna_checker.
module tb_mesh_vertex_normal_accumulator;
    import mvna_pkg::*;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic                    i_action = ACT_LOAD;
    logic [IDX_W-1:0]        i_vertex_index = '0;
    logic signed [POS_W-1:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic [IDX_W-1:0]        i_corner_a = '0, i_corner_b = '0, i_corner_c = '0;
    logic                    i_end_of_mesh = 1'b0;
    logic                    o_valid;
    logic [IDX_W-1:0]        o_vertex_id;
    logic signed [NRM_W-1:0] o_normal_x, o_normal_y, o_normal_z;
    logic                    o_degenerate, o_last_corner, o_mesh_done;
    int                      err_count, pending_beats;

    int loaded [$];
    int idle_pct;

    always #10 i_clk = ~i_clk;

    mesh_vertex_normal_accumulator dut (.*);

    mvna_checker chk (.*, .o_errors(err_count), .o_pending(pending_beats));

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    // Busy only changes after a rising edge, so it is checked at the falling edge.
    task automatic issue(input logic act, input int vi, input int px, input int py,
                         input int pz, input int ca, input int cb, input int cc,
                         input logic eom);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start = 1'b0;
            repeat ($urandom_range(1, 30)) @(negedge i_clk);
        end
        start          = 1'b1;
        i_action       = act;
        i_vertex_index = IDX_W'(vi);
        i_pos_x        = POS_W'(px);
        i_pos_y        = POS_W'(py);
        i_pos_z        = POS_W'(pz);
        i_corner_a     = IDX_W'(ca);
        i_corner_b     = IDX_W'(cb);
        i_corner_c     = IDX_W'(cc);
        i_end_of_mesh  = eom;
        while (busy) @(negedge i_clk);
        @(negedge i_clk);
        if (act == ACT_LOAD && !(vi inside {loaded})) loaded.push_back(vi);
    endtask

    task automatic load_vertex(input int vi, input int px, input int py, input int pz);
        issue(ACT_LOAD, vi, px, py, pz, $urandom, $urandom, $urandom, 1'($urandom));
    endtask

    task automatic triangle(input int ca, input int cb, input int cc, input logic eom);
        issue(ACT_TRI, $urandom, $urandom, $urandom, $urandom, ca, cb, cc, eom);
    endtask

    function automatic int pick_loaded();
        return loaded[$urandom_range(loaded.size() - 1)];
    endfunction

    initial begin
        int ca, cb, cc;
        idle_pct = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extreme positions and indices, degenerate and repeated corners.
        load_vertex(0, 0, 0, 0);
        load_vertex(1023, 32767, 32767, 32767);
        load_vertex(1, -32768, -32768, -32768);
        load_vertex(2, 32767, -32768, 0);
        load_vertex(3, -32768, 32767, 32767);
        load_vertex(4, 256, 0, 0);
        load_vertex(5, 0, 256, 0);
        load_vertex(6, 512, 0, 0);
        triangle(0, 4, 5, 1'b0);
        triangle(0, 4, 5, 1'b0);
        triangle(0, 4, 6, 1'b0);
        triangle(7'd4, 4, 4, 1'b0);
        triangle(0, 0, 5, 1'b0);
        triangle(1023, 1, 2, 1'b0);
        triangle(1, 2, 3, 1'b0);
        triangle(3, 1023, 1, 1'b1);
        load_vertex(0, 1, -1, 1);
        triangle(0, 1023, 2, 1'b1);

        // Random phases; the receiver cannot stall, so only the sender idles.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                1:       idle_pct = 48;
                2:       idle_pct = 9;
                default: idle_pct = 0;
            endcase
            for (int n = 0; n < 50; n++) begin
                if (ph == 2 && n == 25) begin
                    start = 1'b0;
                    while (pending_beats != 0) @(negedge i_clk);
                end
                if ($urandom_range(99) < 25 || loaded.size() < 4) begin
                    load_vertex(($urandom_range(1) != 0) ? pick_loaded() : $urandom_range(1023),
                                $urandom, $urandom, $urandom);
                end else begin
                    ca = pick_loaded();
                    cb = pick_loaded();
                    cc = pick_loaded();
                    if ($urandom_range(99) < 10) cc = ca;
                    triangle(ca, cb, cc, 1'($urandom_range(1)));
                end
            end
        end
        start = 1'b0;
        while (pending_beats != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        if (err_count == 0) begin
            $display("tb_mesh_vertex_normal_accumulator: clean");
        end else begin
            $display("tb_mesh_vertex_normal_accumulator: errors");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb_mesh_vertex_normal_accumulator: errors");
        $finish;
    end

endmodule

>>> mesh_vertex_normal_accumulator.f
design/mvna_pkg.sv
design/mvna_ram.sv
design/mvna_isqrt.sv
design/mvna_divlane.sv
design/mesh_vertex_normal_accumulator.sv
bench/mvna_checker.sv
bench/tb_mesh_vertex_normal_accumulator.sv
